// File: sv/urc_pkg.sv
// Shared types and constants for the ultrasonic range controller.
// No dependencies; imported by every module of the block.
package urc_pkg;

    localparam int ECHO_COUNT_BITS = 16;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_TICKS_PER_US = 3'd0;
    localparam logic [2:0] REG_TRIGGER_US   = 3'd1;
    localparam logic [2:0] REG_GAP_US       = 3'd2;
    localparam logic [2:0] REG_NEAR_CM      = 3'd3;
    localparam logic [2:0] REG_MID_CM       = 3'd4;
    localparam logic [2:0] REG_MAX_CM       = 3'd5;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 17;

    // Reset values of the registers
    localparam logic [7:0]  RST_TICKS_PER_US = 8'd40;
    localparam logic [7:0]  RST_TRIGGER_US   = 8'd10;
    localparam logic [16:0] RST_GAP_US       = 17'd61000;
    localparam logic [7:0]  RST_NEAR_CM      = 8'd20;
    localparam logic [7:0]  RST_MID_CM       = 8'd50;
    localparam logic [7:0]  RST_MAX_CM       = 8'd200;

    // Sequencer and conversion constants
    localparam logic [16:0] FIRST_WAIT_US = 17'd5;
    localparam logic [4:0]  US_STEP_LAST  = 5'd19;    // 20 us per distance step
    localparam logic [10:0] CM_NUM        = 11'd332;
    localparam logic [10:0] CM_DEN        = 11'd1000;
    localparam logic [8:0]  DIST_CAP      = 9'd256;   // above any max_cm

    // Zone codes
    localparam logic [1:0] ZONE_NEAR = 2'd0;
    localparam logic [1:0] ZONE_MID  = 2'd1;
    localparam logic [1:0] ZONE_FAR  = 2'd2;

    typedef struct packed {
        logic [7:0]  ticks_per_us;
        logic [7:0]  trigger_us;
        logic [16:0] gap_us;
        logic [7:0]  near_cm;
        logic [7:0]  mid_cm;
        logic [7:0]  max_cm;
    } cfg_t;

    typedef struct packed {
        logic [1:0] zone;
        logic [7:0] distance_cm;
        logic       distance_valid;
        logic       trigger_level;
    } result_t;

endpackage

// File: sv/ultrasonic_range_controller.sv
// Top level of the ultrasonic range controller: stream ports, input and result registers.
// Depends on urc_pkg, urc_cfg and urc_core.
//
// Usage:
// - Slave stream (s_*): one word per clock tick of the echo pin sampler,
//   s_tdata[0] is the sampled echo level.
// - Master stream (m_*): one result word for every input word, in order:
//   trigger drive, distance valid pulse, distance in cm, zone.
// - Configuration: cfg_we writes cfg_data into register cfg_index at the
//   clock edge; write only while no word is in flight.
// - Path: an accepted word is held in the input register, passes
//   through the tick logic and lands in the result register once the
//   result register is free or being drained; it is visible on m_* after that.
// - Throughput: one word per cycle while the result register is free or being drained.
// - Stall: when m_tready is low the result register holds, the input register
//   keeps its word and s_tready drops once both are full; no state advances.
// - Reset: trigger low, first wait of 5 us, distance 0, zone near, registers
//   at their reset values, both stream registers empty.
// - Distance is tracked during the echo pulse with a 20 us step counter and a
//   mod-1000 accumulator, so the falling edge only clamps against max_cm.
module ultrasonic_range_controller
    import urc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    // Input stream
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,   // [0] echo_level, [7:1] zero
    // Result stream
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [15:0]               m_tdata,   // [0] trigger_level, [1] distance_valid,
                                                 // [9:2] distance_cm, [11:10] zone, [15:12] zero
    // Configuration
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    cfg_t    cfg;
    result_t result;
    result_t out_data_reg;
    logic    in_valid_reg;
    logic    echo_reg;
    logic    out_valid_reg;
    logic    advance;

    urc_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Process the held word when the result register can take it
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    urc_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .echo   (echo_reg),
        .cfg    (cfg),
        .result (result)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            echo_reg <= s_tdata[0];
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_data_reg};

endmodule

// File: sv/urc_cfg.sv
// Configuration register file of the ultrasonic range controller.
// Depends on urc_pkg.
module urc_cfg
    import urc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ticks_per_us <= RST_TICKS_PER_US;
            cfg_reg.trigger_us   <= RST_TRIGGER_US;
            cfg_reg.gap_us       <= RST_GAP_US;
            cfg_reg.near_cm      <= RST_NEAR_CM;
            cfg_reg.mid_cm       <= RST_MID_CM;
            cfg_reg.max_cm       <= RST_MAX_CM;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TICKS_PER_US: cfg_reg.ticks_per_us <= cfg_data[7:0];
                REG_TRIGGER_US:   cfg_reg.trigger_us   <= cfg_data[7:0];
                REG_GAP_US:       cfg_reg.gap_us       <= cfg_data;
                REG_NEAR_CM:      cfg_reg.near_cm      <= cfg_data[7:0];
                REG_MID_CM:       cfg_reg.mid_cm       <= cfg_data[7:0];
                REG_MAX_CM:       cfg_reg.max_cm       <= cfg_data[7:0];
                default:          ;   // drop unknown index
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: sv/urc_core.sv
// Per-tick update of the trigger sequencer, echo meter and distance/zone state.
// Depends on urc_pkg; state advances only when step is high.
module urc_core
    import urc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  logic    echo,
    input  cfg_t    cfg,
    output result_t result
);

    localparam logic [ECHO_COUNT_BITS-1:0] CNT_MAX = '1;

    logic                       phase_reg, phase_next;
    logic [16:0]                phase_left_reg, phase_left_next;
    logic [7:0]                 prescale_reg, prescale_next;
    logic [ECHO_COUNT_BITS-1:0] width_reg, width_next;
    logic [4:0]                 sub_reg, sub_next;      // us within a 20 us step
    logic [9:0]                 acc_reg, acc_next;      // steps*332 mod 1000
    logic [8:0]                 dcnt_reg, dcnt_next;    // running distance, capped
    logic                       echo_last_reg, echo_last_next;
    logic [7:0]                 distance_reg, distance_next;
    logic [1:0]                 zone_reg, zone_next;
    logic                       valid;
    logic [7:0]                 tpu;
    logic                       us_tick;
    logic [10:0]                acc_sum;

    always_comb
    begin
        phase_next      = phase_reg;
        phase_left_next = phase_left_reg;
        width_next      = width_reg;
        sub_next        = sub_reg;
        acc_next        = acc_reg;
        dcnt_next       = dcnt_reg;
        echo_last_next  = echo_last_reg;
        distance_next   = distance_reg;
        zone_next       = zone_reg;
        valid           = 1'b0;
        acc_sum         = '0;

        // Edges are seen only in the low phase
        if (!phase_reg)
        begin
            if (!echo_last_reg && echo)
            begin
                width_next     = '0;
                sub_next       = '0;
                acc_next       = '0;
                dcnt_next      = '0;
                echo_last_next = 1'b1;
            end
            else if (echo_last_reg && !echo)
            begin
                distance_next  = (dcnt_reg > {1'b0, cfg.max_cm}) ? cfg.max_cm
                                                                  : dcnt_reg[7:0];
                echo_last_next = 1'b0;
                valid          = 1'b1;
            end
        end

        tpu           = (cfg.ticks_per_us == 8'd0) ? 8'd1 : cfg.ticks_per_us;
        us_tick       = ({1'b0, prescale_reg} + 9'd1) >= {1'b0, tpu};
        prescale_next = us_tick ? 8'd0 : prescale_reg + 8'd1;

        if (us_tick)
        begin
            // Advance the saturating echo counter and its distance shadow
            if (echo_last_next && (width_next < CNT_MAX))
            begin
                width_next = width_next + ECHO_COUNT_BITS'(1);
                if (sub_next == US_STEP_LAST)
                begin
                    sub_next = '0;
                    acc_sum  = {1'b0, acc_next} + CM_NUM;
                    if (acc_sum >= CM_DEN)
                    begin
                        acc_sum = acc_sum - CM_DEN;
                        if (dcnt_next != DIST_CAP)
                            dcnt_next = dcnt_next + 9'd1;
                    end
                    acc_next = acc_sum[9:0];
                end
                else
                begin
                    sub_next = sub_next + 5'd1;
                end
            end

            if (phase_left_reg <= 17'd1)
            begin
                if (!phase_reg)
                begin
                    phase_next      = 1'b1;
                    phase_left_next = {9'd0, cfg.trigger_us};
                end
                else
                begin
                    phase_next      = 1'b0;
                    phase_left_next = cfg.gap_us;
                    if (distance_next < cfg.near_cm)
                        zone_next = ZONE_NEAR;
                    else if (distance_next < cfg.mid_cm)
                        zone_next = ZONE_MID;
                    else
                        zone_next = ZONE_FAR;
                end
            end
            else
            begin
                phase_left_next = phase_left_reg - 17'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= 1'b0;
            phase_left_reg <= FIRST_WAIT_US;
            prescale_reg   <= '0;
            width_reg      <= '0;
            sub_reg        <= '0;
            acc_reg        <= '0;
            dcnt_reg       <= '0;
            echo_last_reg  <= 1'b0;
            distance_reg   <= '0;
            zone_reg       <= ZONE_NEAR;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            phase_left_reg <= phase_left_next;
            prescale_reg   <= prescale_next;
            width_reg      <= width_next;
            sub_reg        <= sub_next;
            acc_reg        <= acc_next;
            dcnt_reg       <= dcnt_next;
            echo_last_reg  <= echo_last_next;
            distance_reg   <= distance_next;
            zone_reg       <= zone_next;
        end
    end

    assign result.trigger_level  = phase_next;
    assign result.distance_valid = valid;
    assign result.distance_cm    = distance_next;
    assign result.zone           = zone_next;

endmodule

// File: verif/urc_checker.sv
// Checker for the ultrasonic range controller: watches the echo, result and configuration ports,
// predicts every result word and compares it field by field.
// Depends on urc_pkg.
module urc_checker
    import urc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [7:0]                s_tdata,   // [0] echo_level, [7:1] zero
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [15:0]               m_tdata,   // [0] trigger_level, [1] distance_valid,
                                                 // [9:2] distance_cm, [11:10] zone, [15:12] zero
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output int                        words_pending,
    output int                        mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned US_PER_STEP = 20;
    localparam int unsigned CM_NUM_X    = 332;
    localparam int unsigned CM_DEN_X    = 1000;

    cfg_t                       shadow_cfg;
    logic                       seq_high;
    logic [16:0]                us_left;
    logic [7:0]                 tick_div;
    logic [ECHO_COUNT_BITS-1:0] pulse_us;
    logic                       echo_seen;
    logic [7:0]                 dist_hold;
    logic [1:0]                 zone_hold;
    result_t                    expected_words[$];
    int                         mismatch_count = 0;

    // Advance the ranger by one accepted word and return the result word it leaves behind.
    function automatic result_t step_ranger(input logic echo);
        result_t     r;
        logic [7:0]  tpu;
        int unsigned cm;
        r = '0;
        // Echo edges count only while the trigger is low
        if (!seq_high) begin
            if (!echo_seen && echo) begin
                pulse_us  = '0;
                echo_seen = 1'b1;
            end
            else if (echo_seen && !echo) begin
                cm = ((int'(pulse_us) / US_PER_STEP) * CM_NUM_X) / CM_DEN_X;
                dist_hold = (cm > shadow_cfg.max_cm) ? shadow_cfg.max_cm : cm[7:0];
                echo_seen = 1'b0;
                r.distance_valid = 1'b1;
            end
        end
        tpu = (shadow_cfg.ticks_per_us == 8'd0) ? 8'd1 : shadow_cfg.ticks_per_us;
        if (int'(tick_div) + 1 >= int'(tpu)) begin
            tick_div = '0;
            if (echo_seen && pulse_us != '1)
                pulse_us++;
            if (us_left <= 17'd1) begin
                if (!seq_high) begin
                    seq_high = 1'b1;
                    us_left  = {9'd0, shadow_cfg.trigger_us};
                end
                else begin
                    seq_high = 1'b0;
                    us_left  = shadow_cfg.gap_us;
                    if (dist_hold < shadow_cfg.near_cm)
                        zone_hold = ZONE_NEAR;
                    else if (dist_hold < shadow_cfg.mid_cm)
                        zone_hold = ZONE_MID;
                    else
                        zone_hold = ZONE_FAR;
                end
            end
            else begin
                us_left--;
            end
        end
        else begin
            tick_div++;
        end
        r.trigger_level = seq_high;
        r.distance_cm   = dist_hold;
        r.zone          = zone_hold;
        return r;
    endfunction

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        result_t want;
        result_t got;
        if (!rst_n) begin
            shadow_cfg.ticks_per_us = RST_TICKS_PER_US;
            shadow_cfg.trigger_us   = RST_TRIGGER_US;
            shadow_cfg.gap_us       = RST_GAP_US;
            shadow_cfg.near_cm      = RST_NEAR_CM;
            shadow_cfg.mid_cm       = RST_MID_CM;
            shadow_cfg.max_cm       = RST_MAX_CM;
            seq_high  = 1'b0;
            us_left   = FIRST_WAIT_US;
            tick_div  = '0;
            pulse_us  = '0;
            echo_seen = 1'b0;
            dist_hold = '0;
            zone_hold = ZONE_NEAR;
            expected_words.delete();
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_TICKS_PER_US: shadow_cfg.ticks_per_us = cfg_data[7:0];
                    REG_TRIGGER_US:   shadow_cfg.trigger_us   = cfg_data[7:0];
                    REG_GAP_US:       shadow_cfg.gap_us       = cfg_data;
                    REG_NEAR_CM:      shadow_cfg.near_cm      = cfg_data[7:0];
                    REG_MID_CM:       shadow_cfg.mid_cm       = cfg_data[7:0];
                    REG_MAX_CM:       shadow_cfg.max_cm       = cfg_data[7:0];
                    default: ;
                endcase
            end
            // Retire before predicting: a word taken at this edge cannot leave yet
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[11:0]);
                if (expected_words.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result word with nothing expected, got %h", $time, got);
                end
                else begin
                    want = expected_words.pop_front();
                    check_field("trigger_level", 32'(want.trigger_level),
                                32'(got.trigger_level));
                    check_field("distance_valid", 32'(want.distance_valid),
                                32'(got.distance_valid));
                    check_field("distance_cm", 32'(want.distance_cm), 32'(got.distance_cm));
                    check_field("zone", 32'(want.zone), 32'(got.zone));
                end
            end
            if (s_tvalid && s_tready)
                expected_words.push_back(step_ranger(s_tdata[0]));
        end
        words_pending <= expected_words.size();
        mismatches    <= mismatch_count;
    end

endmodule

// File: verif/tb_ultrasonic_range_controller.sv
// Testbench top for the ultrasonic range controller: clock, reset, echo stimulus, result
// back-pressure, register programming and the verdict.
// Depends on urc_pkg, urc_checker and the controller RTL.
module tb_ultrasonic_range_controller;
    import urc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles with no word moving on either side before the run is called dead
    localparam int IDLE_LIMIT      = 4000;
    // Long receiver hold-off, long enough to fill the block and stall its input
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int RANDOM_WORDS    = 600;
    localparam int WORDS_PER_PHASE = 100;
    // Echo high long enough to run past the clamp at the lowered max_cm
    localparam int EXTREME_HIGHS   = 200;
    // Indexes past the last register; writes there must be dropped
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_B = 3'd7;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [7:0]                s_tdata   = '0;
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [15:0]               m_tdata;
    logic                      cfg_we    = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

    int words_pending;
    int mismatches;
    int stall_cycles = 0;
    int words_sent   = 0;
    // calm: no idling on either side for this phase
    bit calm         = 1'b0;
    bit hold_off_req = 1'b0;

    always #5 clk = ~clk;

    ultrasonic_range_controller i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    urc_checker i_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .words_pending (words_pending),
        .mismatches    (mismatches)
    );

    // Idle length: mostly none, often a few cycles, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one echo sample and hold it until the block takes it. valid stays
    // high across back-to-back words, so it is only lowered for a real gap.
    task automatic send_echo(input logic echo);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, echo};
        do
            @(posedge clk);
        while (!s_tready);
        words_sent++;
    endtask

    // One well-formed echo: a low run, then a high run
    task automatic send_pulse(input int lows, input int highs);
        repeat (lows) send_echo(1'b0);
        repeat (highs) send_echo(1'b1);
    endtask

    // Raise the write strobe for one edge; the caller drops it after the last write
    task automatic put_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic apply_config(input cfg_t c);
        put_reg(REG_TICKS_PER_US, {9'd0, c.ticks_per_us});
        put_reg(REG_TRIGGER_US, {9'd0, c.trigger_us});
        put_reg(REG_GAP_US, c.gap_us);
        put_reg(REG_NEAR_CM, {9'd0, c.near_cm});
        put_reg(REG_MID_CM, {9'd0, c.mid_cm});
        put_reg(REG_MAX_CM, {9'd0, c.max_cm});
        cfg_we <= 1'b0;
    endtask

    // Stop offering, wait until every expected word is back, then let the
    // pipeline settle before any register write.
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (words_pending != 0);
        repeat (3) @(posedge clk);
    endtask

    // Receiver: random stalls, calm stretches, and one long hold-off on request
    initial begin
        int n;
        @(posedge rst_n);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else if (calm) begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
            else begin
                n = pick_gap();
                if (n > 0) begin
                    m_tready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    // Watchdog: count cycles in which no word moves on either stream
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end
        else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= IDLE_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        cfg_t c;
        int   rnd_start;
        int   ph_start;
        int   ph;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: the first 5 us wait outlasts all words sent here, so
        // every edge here lands in the low phase. Short pulses and one-tick glitches.
        send_pulse(2, 5);
        send_echo(1'b1);
        send_echo(1'b0);
        send_echo(1'b1);
        send_echo(1'b0);
        send_pulse(3, 6);
        send_echo(1'b0);
        drain();

        // All registers zero: every tick is a microsecond tick, the prescaler
        // sits above the lowered divider, both phases end on the next tick so
        // echo edges land in both phases, and the clamp is zero.
        // Poke the unused indexes first; those writes must change nothing.
        put_reg(REG_SPARE_A, '1);
        put_reg(REG_SPARE_B, '1);
        c = '0;
        apply_config(c);
        repeat (4) send_pulse(1, 2);
        send_pulse(2, 1);
        send_pulse(1, 4);
        send_echo(1'b0);
        drain();

        // Upper extremes of the timing registers: long trigger and gap, one
        // tick per microsecond, and a pulse that runs past a low clamp.
        c = '{ticks_per_us: 8'd1, trigger_us: 8'd255, gap_us: 17'h1FFFF,
              near_cm: 8'd1, mid_cm: 8'd2, max_cm: 8'd2};
        calm = 1'b1;
        apply_config(c);
        send_pulse(1, EXTREME_HIGHS);
        send_pulse(30, 0);
        calm = 1'b0;
        drain();

        // Random phases: mostly well-formed pulses with random widths, some
        // noise bursts; a fresh register set per phase.
        rnd_start = words_sent;
        ph = 0;
        while (words_sent - rnd_start < RANDOM_WORDS) begin
            c.ticks_per_us = (ph == 0) ? 8'd255 :
                             ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 3));
            c.trigger_us   = 8'($urandom_range(1, 8));
            c.gap_us       = 17'($urandom_range(5, 150));
            c.near_cm      = 8'($urandom_range(0, 6));
            c.mid_cm       = c.near_cm + 8'($urandom_range(0, 12));
            c.max_cm       = ($urandom_range(0, 3) == 0) ? 8'd255 : 8'($urandom_range(0, 30));
            apply_config(c);
            calm = (ph % 4 == 3);
            // Hold the receiver off while words keep coming: fill and stall the input
            if (ph == 1)
                hold_off_req = 1'b1;
            ph_start = words_sent;
            while (words_sent - ph_start < WORDS_PER_PHASE) begin
                if ($urandom_range(0, 4) != 0)
                    send_pulse($urandom_range(1, 20),
                               ($urandom_range(0, 9) == 0) ? $urandom_range(150, 300)
                                                           : $urandom_range(1, 120));
                else
                    repeat ($urandom_range(1, 10)) send_echo(1'($urandom_range(0, 1)));
            end
            calm = 1'b0;
            drain();
            ph++;
        end

        // Let any stray word show up before the verdict
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
